// File: rtl/scfe_pkg.sv
// Shared types, constants and helper functions of the SLIP/CRC16 frame encoder.
package scfe_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int BURST_LEN   = 8;
    localparam int BURST_IDX_W = $clog2(BURST_LEN);
    localparam int BURST_POS_W = BURST_IDX_W + 1;

    localparam logic [7:0] MARK_START    = 8'hA5;
    localparam logic [7:0] MARK_END      = 8'hC0;
    localparam logic [7:0] ESC_BYTE      = 8'hDB;
    localparam logic [7:0] ESC_FOR_END   = 8'hDC;
    localparam logic [7:0] ESC_FOR_ESC   = 8'hDD;
    localparam logic [7:0] ESC_FOR_START = 8'hDE;
    localparam logic [7:0] ESC_FOR_CR    = 8'hD0;
    localparam logic [7:0] ESC_FOR_LF    = 8'hD1;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       end_mark;
    } res_t;

    typedef struct packed {
        res_t [BURST_LEN-1:0]   entry;
        logic [BURST_IDX_W-1:0] last;
    } burst_t;

    typedef struct packed {
        logic       esc;
        logic [7:0] code;
    } esc_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic esc_t escape_byte(input logic [7:0] b);
        esc_t e;
        e.esc  = 1'b1;
        e.code = b;
        case (b)
            MARK_START: e.code = ESC_FOR_START;
            MARK_END:   e.code = ESC_FOR_END;
            ESC_BYTE:   e.code = ESC_FOR_ESC;
            CHAR_CR:    e.code = ESC_FOR_CR;
            CHAR_LF:    e.code = ESC_FOR_LF;
            default:    e.esc  = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// File: rtl/slip_crc16_frame_encoder_core.sv
// Top level of the SLIP framing encoder with CRC-16/CCITT trailer.
// An accepted byte is held as a burst; its wire bytes then pass through the output register.
// Throughput: one wire byte per cycle while m_tready allows; an input byte makes 1 to 8 wire
// bytes through the single output register, and the next is taken as its last one loads.
// Reset (aresetn low, synchronous): no frame open, CRC 0xFFFF, outputs empty.
module slip_crc16_frame_encoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] frame_start
    input  logic       s_tlast,   // frame_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] status, [2] frame_marker_end
    output logic       m_tlast    // run_last
);

    logic             in_accept;
    scfe_pkg::burst_t burst;
    scfe_pkg::res_t   m_res;

    assign in_accept = s_tvalid && s_tready;

    scfe_frame_ctl u_frame_ctl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .frame_end   (s_tlast),
        .burst       (burst)
    );

    scfe_burst_out u_burst_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .burst_in  (burst),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res),
        .m_last    (m_tlast)
    );

    assign m_tdata = m_res.data;
    assign m_tuser = {m_res.end_mark, m_res.status};

endmodule

// File: rtl/scfe_frame_ctl.sv
// Frame state (CRC, open flag, payload count) and per-byte result burst builder.
module scfe_frame_ctl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            data_byte,
    input  logic                  frame_start,
    input  logic                  frame_end,
    output scfe_pkg::burst_t      burst
);

    logic [15:0]                  crc_reg, crc_next;
    logic                         in_frame_reg, in_frame_next;
    logic [scfe_pkg::COUNT_W-1:0] count_reg, count_next;

    logic        over;
    logic        take_data;
    logic [15:0] crc_upd;
    logic [15:0] crc_out;

    assign over      = count_reg >= scfe_pkg::COUNT_W'(scfe_pkg::MAX_PAYLOAD);
    assign take_data = frame_start || (in_frame_reg && !over);
    assign crc_upd   = scfe_pkg::crc_byte(frame_start ? scfe_pkg::CRC_INIT : crc_reg, data_byte);
    assign crc_out   = take_data ? crc_upd : crc_reg;

    always_comb begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (frame_start) begin
            crc_next      = crc_upd;
            count_next    = '0;
            in_frame_next = !frame_end;
        end else if (in_frame_reg) begin
            if (!over) begin
                crc_next   = crc_upd;
                count_next = count_reg + scfe_pkg::COUNT_W'(1);
            end
            if (frame_end) begin
                in_frame_next = 1'b0;
            end
        end
    end

    always_comb begin
        scfe_pkg::esc_t                 e_data;
        scfe_pkg::esc_t                 e_lo;
        scfe_pkg::esc_t                 e_hi;
        logic [scfe_pkg::BURST_POS_W-1:0] pos;
        logic [scfe_pkg::BURST_POS_W-1:0] pos_p1;
        logic [scfe_pkg::BURST_POS_W-1:0] pos_m1;
        e_data = scfe_pkg::escape_byte(data_byte);
        e_lo   = scfe_pkg::escape_byte(crc_out[7:0]);
        e_hi   = scfe_pkg::escape_byte(crc_out[15:8]);
        burst  = '0;
        pos    = '0;
        pos_p1 = '0;
        if (frame_start) begin
            burst.entry[0] = '{data: scfe_pkg::MARK_START, status: scfe_pkg::ST_OK,
                               end_mark: 1'b0};
            pos = scfe_pkg::BURST_POS_W'(1);
        end else if (!in_frame_reg) begin
            burst.entry[0] = '{data: 8'h00, status: scfe_pkg::ST_OUTSIDE, end_mark: 1'b0};
            pos = scfe_pkg::BURST_POS_W'(1);
        end else if (over) begin
            burst.entry[0] = '{data: 8'h00, status: scfe_pkg::ST_TOO_LONG, end_mark: 1'b0};
            pos = scfe_pkg::BURST_POS_W'(1);
        end
        if (take_data) begin
            pos_p1 = pos + scfe_pkg::BURST_POS_W'(1);
            if (e_data.esc) begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: scfe_pkg::ESC_BYTE, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                burst.entry[pos_p1[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: e_data.code, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos + scfe_pkg::BURST_POS_W'(2);
            end else begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: data_byte, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos_p1;
            end
        end
        if (frame_end && (frame_start || in_frame_reg)) begin
            pos_p1 = pos + scfe_pkg::BURST_POS_W'(1);
            if (e_lo.esc) begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: scfe_pkg::ESC_BYTE, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                burst.entry[pos_p1[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: e_lo.code, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos + scfe_pkg::BURST_POS_W'(2);
            end else begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: crc_out[7:0], status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos_p1;
            end
            pos_p1 = pos + scfe_pkg::BURST_POS_W'(1);
            if (e_hi.esc) begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: scfe_pkg::ESC_BYTE, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                burst.entry[pos_p1[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: e_hi.code, status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos + scfe_pkg::BURST_POS_W'(2);
            end else begin
                burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                    '{data: crc_out[15:8], status: scfe_pkg::ST_OK, end_mark: 1'b0};
                pos = pos_p1;
            end
            burst.entry[pos[scfe_pkg::BURST_IDX_W-1:0]] =
                '{data: scfe_pkg::MARK_END, status: scfe_pkg::ST_OK, end_mark: 1'b1};
            pos = pos + scfe_pkg::BURST_POS_W'(1);
        end
        pos_m1     = pos - scfe_pkg::BURST_POS_W'(1);
        burst.last = pos_m1[scfe_pkg::BURST_IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= scfe_pkg::CRC_INIT;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else if (in_accept) begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= scfe_pkg::COUNT_W'(scfe_pkg::MAX_PAYLOAD))
        else $error("payload count beyond maximum");

    a_start_resets_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && frame_start |=> count_reg == '0)
        else $error("frame start did not clear payload count");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && frame_end |=> !in_frame_reg)
        else $error("frame still open after end byte");
`endif

endmodule

// File: rtl/scfe_burst_out.sv
// Burst holding register and output register that stream results one per cycle while m_tready allows.
module scfe_burst_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  scfe_pkg::burst_t  burst_in,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output scfe_pkg::res_t    m_res,
    output logic              m_last
);

    scfe_pkg::burst_t                 burst_reg;
    logic                             burst_valid_reg;
    logic [scfe_pkg::BURST_IDX_W-1:0] idx_reg;
    scfe_pkg::res_t                   out_reg;
    logic                             out_last_reg;
    logic                             m_valid_reg;

    logic load_out;
    logic at_last;

    assign load_out = burst_valid_reg && (!m_valid_reg || m_tready);
    assign at_last  = idx_reg == burst_reg.last;
    assign in_ready = !burst_valid_reg || (load_out && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end else if (in_accept) begin
            burst_valid_reg <= 1'b1;
            idx_reg         <= '0;
        end else if (load_out && at_last) begin
            burst_valid_reg <= 1'b0;
        end else if (load_out) begin
            idx_reg <= idx_reg + scfe_pkg::BURST_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            burst_reg <= burst_in;
        end
        if (load_out) begin
            out_reg      <= burst_reg.entry[idx_reg];
            out_last_reg <= at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_res    = out_reg;
    assign m_last   = out_last_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid_reg |-> idx_reg <= burst_reg.last)
        else $error("burst index past last entry");

    a_end_mark_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.end_mark |-> out_last_reg)
        else $error("end marker not last transfer of its byte");

    a_status_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.status != scfe_pkg::ST_OK |-> out_reg.data == 8'h00)
        else $error("flagged transfer carries data");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> burst_valid_reg && idx_reg == '0)
        else $error("accepted byte not held in burst register");
`endif

endmodule

// File: verif/slip_crc16_frame_encoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SLIP/CRC16 frame encoder, each wire byte scored.
module slip_crc16_frame_encoder_core_tb;

    typedef struct {
        logic [7:0] octet;
        logic       sof;
        logic       eof;
    } in_byte_t;

    typedef struct {
        logic [7:0]        octet;
        scfe_pkg::status_t st;
        logic              run_end;
        logic              close_mark;
    } wire_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tuser  = 1'b0;    // [0] frame_start
    logic       s_tlast  = 1'b0;    // frame_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [2:0] m_tuser;            // [1:0] status, [2] frame_marker_end
    logic       m_tlast;            // run_last

    in_byte_t    pending[$];
    wire_byte_t  wire_q[$];

    logic [15:0] crc_run;
    logic        frame_open;
    int          payload_cnt;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          err_cnt;
    int          gen_cnt;
    logic        gen_open;

    slip_crc16_frame_encoder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // bitwise CRC-16/CCITT, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ scfe_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic bit is_slip_special(input logic [7:0] b);
        return (b == scfe_pkg::MARK_START) || (b == scfe_pkg::MARK_END) ||
               (b == scfe_pkg::ESC_BYTE) || (b == scfe_pkg::CHAR_CR) ||
               (b == scfe_pkg::CHAR_LF);
    endfunction

    task automatic push_wire(input logic [7:0] octet, input scfe_pkg::status_t st,
                             input logic close_mark);
        wire_byte_t w;
        w.octet      = octet;
        w.st         = st;
        w.run_end    = 1'b0;
        w.close_mark = close_mark;
        wire_q.push_back(w);
    endtask

    task automatic push_escaped(input logic [7:0] b);
        case (b)
            scfe_pkg::MARK_START: begin
                push_wire(scfe_pkg::ESC_BYTE, scfe_pkg::ST_OK, 1'b0);
                push_wire(scfe_pkg::ESC_FOR_START, scfe_pkg::ST_OK, 1'b0);
            end
            scfe_pkg::MARK_END: begin
                push_wire(scfe_pkg::ESC_BYTE, scfe_pkg::ST_OK, 1'b0);
                push_wire(scfe_pkg::ESC_FOR_END, scfe_pkg::ST_OK, 1'b0);
            end
            scfe_pkg::ESC_BYTE: begin
                push_wire(scfe_pkg::ESC_BYTE, scfe_pkg::ST_OK, 1'b0);
                push_wire(scfe_pkg::ESC_FOR_ESC, scfe_pkg::ST_OK, 1'b0);
            end
            scfe_pkg::CHAR_CR: begin
                push_wire(scfe_pkg::ESC_BYTE, scfe_pkg::ST_OK, 1'b0);
                push_wire(scfe_pkg::ESC_FOR_CR, scfe_pkg::ST_OK, 1'b0);
            end
            scfe_pkg::CHAR_LF: begin
                push_wire(scfe_pkg::ESC_BYTE, scfe_pkg::ST_OK, 1'b0);
                push_wire(scfe_pkg::ESC_FOR_LF, scfe_pkg::ST_OK, 1'b0);
            end
            default: push_wire(b, scfe_pkg::ST_OK, 1'b0);
        endcase
    endtask

    task automatic push_trailer();
        push_escaped(crc_run[7:0]);
        push_escaped(crc_run[15:8]);
        push_wire(scfe_pkg::MARK_END, scfe_pkg::ST_OK, 1'b1);
        frame_open = 1'b0;
    endtask

    // expected wire bytes for one accepted input transfer
    task automatic encode_byte(input in_byte_t it);
        if (it.sof) begin
            crc_run     = crc16_step(scfe_pkg::CRC_INIT, it.octet);
            payload_cnt = 0;
            frame_open  = 1'b1;
            push_wire(scfe_pkg::MARK_START, scfe_pkg::ST_OK, 1'b0);
            push_escaped(it.octet);
            if (it.eof) push_trailer();
        end else if (!frame_open) begin
            push_wire(8'h00, scfe_pkg::ST_OUTSIDE, 1'b0);
        end else begin
            if (payload_cnt >= scfe_pkg::MAX_PAYLOAD) begin
                push_wire(8'h00, scfe_pkg::ST_TOO_LONG, 1'b0);
            end else begin
                payload_cnt++;
                crc_run = crc16_step(crc_run, it.octet);
                push_escaped(it.octet);
            end
            if (it.eof) push_trailer();
        end
        wire_q[wire_q.size() - 1].run_end = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge aclk) begin : driver
        in_byte_t nxt;
        in_byte_t taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.octet = s_tdata;
                taken.sof   = s_tuser;
                taken.eof   = s_tlast;
                encode_byte(taken);
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.octet;
                    s_tuser  <= nxt.sof;
                    s_tlast  <= nxt.eof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        wire_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (wire_q.size() == 0) begin
                    report_mismatch("unexpected transfer", int'(m_tdata), 0);
                end else begin
                    want = wire_q.pop_front();
                    if (m_tdata !== want.octet)
                        report_mismatch("out_byte", int'(m_tdata), int'(want.octet));
                    if (m_tuser[1:0] !== want.st)
                        report_mismatch("status", int'(m_tuser[1:0]), int'(want.st));
                    if (m_tlast !== want.run_end)
                        report_mismatch("run_last", int'(m_tlast), int'(want.run_end));
                    if (m_tuser[2] !== want.close_mark)
                        report_mismatch("frame_marker_end", int'(m_tuser[2]),
                                        int'(want.close_mark));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(input logic [7:0] octet, input logic sof, input logic eof);
        in_byte_t it;
        it.octet = octet;
        it.sof   = sof;
        it.eof   = eof;
        pending.push_back(it);
        gen_cnt++;
    endtask

    // a quarter of the bytes are drawn from the escaped set
    function automatic logic [7:0] rand_octet();
        logic [7:0] specials [5];
        specials[0] = scfe_pkg::MARK_START;
        specials[1] = scfe_pkg::MARK_END;
        specials[2] = scfe_pkg::ESC_BYTE;
        specials[3] = scfe_pkg::CHAR_CR;
        specials[4] = scfe_pkg::CHAR_LF;
        if ($urandom_range(99) < 25) return specials[$urandom_range(4)];
        return 8'($urandom_range(255));
    endfunction

    // broken frames carry no end flag and get abandoned by the next start
    task automatic add_frame(input int n, input bit broken);
        add_item(rand_octet(), 1'b1, (n == 0) && !broken);
        for (int i = 1; i <= n; i++)
            add_item(rand_octet(), 1'b0, (i == n) && !broken);
        gen_open = broken;
    endtask

    task automatic add_random(input int count);
        int target;
        int r;
        target = gen_cnt + count;
        while (gen_cnt < target) begin
            r = $urandom_range(99);
            if (!gen_open && r < 10) begin
                repeat ($urandom_range(1, 2))
                    add_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end else begin
                add_frame((r < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40),
                          $urandom_range(99) < 10);
            end
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || s_tvalid || wire_q.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        int          lo_n;
        int          hi_n;
        logic [15:0] c;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_cnt        = 0;
        gen_cnt        = 0;
        gen_open       = 1'b0;
        crc_run        = scfe_pkg::CRC_INIT;
        frame_open     = 1'b0;
        payload_cnt    = 0;
        lo_n           = 0;
        hi_n           = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes outside any frame
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1);
        // type-only frame
        add_item(8'h00, 1'b1, 1'b1);
        // every escaped byte in the payload
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(scfe_pkg::MARK_START, 1'b0, 1'b0);
        add_item(scfe_pkg::MARK_END, 1'b0, 1'b0);
        add_item(scfe_pkg::ESC_BYTE, 1'b0, 1'b0);
        add_item(scfe_pkg::CHAR_CR, 1'b0, 1'b0);
        add_item(scfe_pkg::CHAR_LF, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1);
        // start while a frame is open
        add_item(8'h12, 1'b1, 1'b0);
        add_item(8'h34, 1'b0, 1'b0);
        add_item(scfe_pkg::MARK_END, 1'b1, 1'b0);
        add_item(scfe_pkg::CHAR_LF, 1'b0, 1'b1);
        add_item(8'h55, 1'b0, 1'b0);
        add_item(8'h77, 1'b1, 1'b0);
        add_item(scfe_pkg::ESC_BYTE, 1'b1, 1'b1);
        // type-only frames whose CRC bytes need escaping
        for (int t = 0; t < 256; t++) begin
            c = crc16_step(scfe_pkg::CRC_INIT, t[7:0]);
            if (lo_n < 2 && is_slip_special(c[7:0])) begin
                add_item(t[7:0], 1'b1, 1'b1);
                lo_n++;
            end else if (hi_n < 2 && is_slip_special(c[15:8])) begin
                add_item(t[7:0], 1'b1, 1'b1);
                hi_n++;
            end
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            add_random(90);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && wire_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
